// ===== hdl/gmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared constants, operation codes and control types of the group
// membership table.
// ----------------------------------------------------------------------------
package gmt_pkg;

    // default sizes
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_KEY_BITS    = 32;

    // operation codes on func
    localparam logic [2:0] FUNC_ADD   = 3'd0;
    localparam logic [2:0] FUNC_FIND  = 3'd1;
    localparam logic [2:0] FUNC_SET   = 3'd2;
    localparam logic [2:0] FUNC_REM   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // datapath micro-operations
    localparam int UOP_W = 5;
    localparam logic [UOP_W-1:0] UOP_NONE      = 5'd0;
    localparam logic [UOP_W-1:0] UOP_ACCEPT    = 5'd1;
    localparam logic [UOP_W-1:0] UOP_RES_FULL  = 5'd2;
    localparam logic [UOP_W-1:0] UOP_RES_RANGE = 5'd3;
    localparam logic [UOP_W-1:0] UOP_ADD       = 5'd4;
    localparam logic [UOP_W-1:0] UOP_FIND_INIT = 5'd5;
    localparam logic [UOP_W-1:0] UOP_FIND      = 5'd6;
    localparam logic [UOP_W-1:0] UOP_FIND_HIT  = 5'd7;
    localparam logic [UOP_W-1:0] UOP_SG_RD     = 5'd8;
    localparam logic [UOP_W-1:0] UOP_SG_OLD    = 5'd9;
    localparam logic [UOP_W-1:0] UOP_SG_NEW    = 5'd10;
    localparam logic [UOP_W-1:0] UOP_SG_RD_TGT = 5'd11;
    localparam logic [UOP_W-1:0] UOP_SG_INC    = 5'd12;
    localparam logic [UOP_W-1:0] UOP_DROP_DEC  = 5'd13;
    localparam logic [UOP_W-1:0] UOP_DROP_LAST = 5'd14;
    localparam logic [UOP_W-1:0] UOP_DROP_MOVE = 5'd15;
    localparam logic [UOP_W-1:0] UOP_RENUM     = 5'd16;
    localparam logic [UOP_W-1:0] UOP_RM_RD     = 5'd17;
    localparam logic [UOP_W-1:0] UOP_RM_MOVE   = 5'd18;
    localparam logic [UOP_W-1:0] UOP_RM_WR     = 5'd19;
    localparam logic [UOP_W-1:0] UOP_CLEAR     = 5'd20;
    localparam logic [UOP_W-1:0] UOP_PUBLISH   = 5'd21;

    // controller to datapath
    typedef struct packed {
        logic [UOP_W-1:0] uop;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       sg_bad;
        logic       rm_bad;
        logic       tgt_eq_old;
        logic       tgt_eq_gt;
        logic       gt_full;
        logic       cnt_le1;
        logic       hit;
        logic       scan_end;
        logic       out_free;
    } t_stat;

endpackage

// ===== hdl/gmt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/gmt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_ctrl
// Sequencer of the group membership table: steps each operation through
// datapath micro-operations and handles the input handshake.
// ----------------------------------------------------------------------------
module gmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gmt_pkg::t_stat i_stat,
    output gmt_pkg::t_cmd  o_cmd
);
    import gmt_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISP      = 4'd1;
    localparam logic [3:0] S_FIND      = 4'd2;
    localparam logic [3:0] S_SG_OLD    = 4'd3;
    localparam logic [3:0] S_SG_CHK    = 4'd4;
    localparam logic [3:0] S_SG_INC    = 4'd5;
    localparam logic [3:0] S_DROP_CHK  = 4'd6;
    localparam logic [3:0] S_DROP_MOVE = 4'd7;
    localparam logic [3:0] S_RENUM     = 4'd8;
    localparam logic [3:0] S_RM_MOVE   = 4'd9;
    localparam logic [3:0] S_RM_WR     = 4'd10;
    localparam logic [3:0] S_PUB       = 4'd11;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [UOP_W-1:0] n_uop;

    // next state and micro-operation
    always_comb begin
        n_state = r_state;
        n_uop   = UOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_uop   = UOP_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.func)
                    FUNC_ADD: begin
                        n_uop   = i_stat.full ? UOP_RES_FULL : UOP_ADD;
                        n_state = S_PUB;
                    end
                    FUNC_FIND: begin
                        n_uop   = UOP_FIND_INIT;
                        n_state = S_FIND;
                    end
                    FUNC_SET: begin
                        if (i_stat.sg_bad) begin
                            n_uop   = UOP_RES_RANGE;
                            n_state = S_PUB;
                        end else begin
                            n_uop   = UOP_SG_RD;
                            n_state = S_SG_OLD;
                        end
                    end
                    FUNC_REM: begin
                        if (i_stat.rm_bad) begin
                            n_uop   = UOP_RES_RANGE;
                            n_state = S_PUB;
                        end else begin
                            n_uop   = UOP_RM_RD;
                            n_state = S_RM_MOVE;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_uop   = UOP_CLEAR;
                        n_state = S_PUB;
                    end
                    default: begin
                        n_uop   = UOP_RES_RANGE;
                        n_state = S_PUB;
                    end
                endcase
            end
            S_FIND: begin
                if (i_stat.hit) begin
                    n_uop   = UOP_FIND_HIT;
                    n_state = S_PUB;
                end else if (i_stat.scan_end) begin
                    n_state = S_PUB;
                end else begin
                    n_uop = UOP_FIND;
                end
            end
            S_SG_OLD: begin
                n_uop   = UOP_SG_OLD;
                n_state = S_SG_CHK;
            end
            S_SG_CHK: begin
                // same group, a lone entry moved to a new group, or a new group with none free: no change
                if (i_stat.tgt_eq_old) begin
                    n_state = S_PUB;
                end else if (i_stat.tgt_eq_gt) begin
                    if (i_stat.gt_full || i_stat.cnt_le1) begin
                        n_state = S_PUB;
                    end else begin
                        n_uop   = UOP_SG_NEW;
                        n_state = S_DROP_CHK;
                    end
                end else begin
                    n_uop   = UOP_SG_RD_TGT;
                    n_state = S_SG_INC;
                end
            end
            S_SG_INC: begin
                n_uop   = UOP_SG_INC;
                n_state = S_DROP_CHK;
            end
            S_DROP_CHK: begin
                if (i_stat.cnt_le1) begin
                    n_uop   = UOP_DROP_LAST;
                    n_state = S_DROP_MOVE;
                end else begin
                    n_uop   = UOP_DROP_DEC;
                    n_state = S_PUB;
                end
            end
            S_DROP_MOVE: begin
                n_uop   = UOP_DROP_MOVE;
                n_state = S_RENUM;
            end
            S_RENUM: begin
                if (i_stat.scan_end) begin
                    n_state = S_PUB;
                end else begin
                    n_uop = UOP_RENUM;
                end
            end
            S_RM_MOVE: begin
                n_uop   = UOP_RM_MOVE;
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                n_uop   = UOP_RM_WR;
                n_state = S_DROP_CHK;
            end
            S_PUB: begin
                if (i_stat.out_free) begin
                    n_uop   = UOP_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.uop  = n_uop;

endmodule

// ===== hdl/gmt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_datapath
// Key, group and member-count memories, table counters, scan pointer and the
// result register of the group membership table.
// ----------------------------------------------------------------------------
module gmt_datapath #(
    parameter int MAX_ENTRIES = gmt_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = gmt_pkg::DEF_KEY_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gmt_pkg::t_cmd  i_cmd,
    output gmt_pkg::t_stat o_stat,
    input  logic [2:0]     i_func,
    input  logic [31:0]    i_tile_key,
    input  logic [5:0]     i_entry_index,
    input  logic [6:0]     i_target_group,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_found,
    output logic [5:0]     o_result_index,
    output logic [1:0]     o_status,
    output logic [6:0]     o_entries_in_use,
    output logic [6:0]     o_groups_in_use
);
    import gmt_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam int KS    = (KEY_BITS < 32) ? KEY_BITS : 32;

    // latched item
    logic [2:0]       r_func;
    logic [KS-1:0]    r_key;
    logic [5:0]       r_idx;
    logic [6:0]       r_tgt;
    // table state and work registers
    logic [CNT_W-1:0] r_et;
    logic [CNT_W-1:0] r_gt;
    logic [IDX_W-1:0] r_old;
    logic [CNT_W-1:0] r_scan;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic             r_found;
    logic [5:0]       r_rindex;
    logic [1:0]       r_status;
    // output register
    logic             r_ovalid;
    logic             r_o_found;
    logic [5:0]       r_o_rindex;
    logic [1:0]       r_o_status;
    logic [6:0]       r_o_et;
    logic [6:0]       r_o_gt;

    // memory ports
    logic             key_we;
    logic [IDX_W-1:0] key_waddr;
    logic [KS-1:0]    key_wdata;
    logic [IDX_W-1:0] key_raddr;
    logic [KS-1:0]    key_rdata;
    logic             goe_we;
    logic [IDX_W-1:0] goe_waddr;
    logic [IDX_W-1:0] goe_wdata;
    logic [IDX_W-1:0] goe_raddr;
    logic [IDX_W-1:0] goe_rdata;
    logic             gmc_we;
    logic [IDX_W-1:0] gmc_waddr;
    logic [CNT_W-1:0] gmc_wdata;
    logic [IDX_W-1:0] gmc_raddr;
    logic [CNT_W-1:0] gmc_rdata;

    logic [UOP_W-1:0] uop;
    logic             scan_more;
    logic             renum_hit;
    logic             out_free;

    assign uop       = i_cmd.uop;
    assign scan_more = (r_scan < r_et);
    assign renum_hit = r_pend && (goe_rdata == IDX_W'(r_gt));
    assign out_free  = !r_ovalid || i_out_ready;

    // memory address and write control
    always_comb begin
        key_we    = 1'b0;
        key_waddr = IDX_W'(r_et);
        key_wdata = r_key;
        key_raddr = IDX_W'(r_scan);
        goe_we    = 1'b0;
        goe_waddr = IDX_W'(r_idx);
        goe_wdata = IDX_W'(r_tgt);
        goe_raddr = IDX_W'(r_idx);
        gmc_we    = 1'b0;
        gmc_waddr = r_old;
        gmc_wdata = gmc_rdata;
        gmc_raddr = r_old;
        case (uop)
            UOP_ADD: begin
                key_we    = 1'b1;
                goe_we    = 1'b1;
                goe_waddr = IDX_W'(r_et);
                goe_wdata = IDX_W'(r_gt);
                gmc_we    = 1'b1;
                gmc_waddr = IDX_W'(r_gt);
                gmc_wdata = CNT_W'(1);
            end
            UOP_SG_OLD: begin
                gmc_raddr = goe_rdata;
            end
            UOP_SG_NEW: begin
                goe_we    = 1'b1;
                gmc_we    = 1'b1;
                gmc_waddr = IDX_W'(r_gt);
                gmc_wdata = CNT_W'(1);
            end
            UOP_SG_RD_TGT: begin
                gmc_raddr = IDX_W'(r_tgt);
            end
            UOP_SG_INC: begin
                goe_we    = 1'b1;
                gmc_we    = 1'b1;
                gmc_waddr = IDX_W'(r_tgt);
                gmc_wdata = gmc_rdata + CNT_W'(1);
            end
            UOP_DROP_DEC: begin
                gmc_we    = 1'b1;
                gmc_wdata = gmc_rdata - CNT_W'(1);
            end
            UOP_DROP_LAST: begin
                gmc_raddr = IDX_W'(r_gt - CNT_W'(1));
            end
            UOP_DROP_MOVE: begin
                gmc_we = 1'b1;
            end
            UOP_RENUM: begin
                // rewrite the previous entry while reading the next one
                goe_raddr = IDX_W'(r_scan);
                goe_we    = renum_hit;
                goe_waddr = r_pidx;
                goe_wdata = r_old;
            end
            UOP_RM_RD: begin
                key_raddr = IDX_W'(r_et - CNT_W'(1));
            end
            UOP_RM_MOVE: begin
                key_we    = 1'b1;
                key_waddr = IDX_W'(r_idx);
                key_wdata = key_rdata;
                goe_raddr = IDX_W'(r_et - CNT_W'(1));
            end
            UOP_RM_WR: begin
                goe_we    = 1'b1;
                goe_wdata = goe_rdata;
            end
            default: begin
            end
        endcase
    end

    gmt_ram #(
        .WIDTH (KS),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (key_waddr),
        .i_wr_data (key_wdata),
        .i_rd_addr (key_raddr),
        .o_rd_data (key_rdata)
    );

    gmt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_goe_ram (
        .i_clk     (i_clk),
        .i_wr_en   (goe_we),
        .i_wr_addr (goe_waddr),
        .i_wr_data (goe_wdata),
        .i_rd_addr (goe_raddr),
        .o_rd_data (goe_rdata)
    );

    gmt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_gmc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (gmc_we),
        .i_wr_addr (gmc_waddr),
        .i_wr_data (gmc_wdata),
        .i_rd_addr (gmc_raddr),
        .o_rd_data (gmc_rdata)
    );

    // counters, scan pointer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_et     <= '0;
            r_gt     <= '0;
            r_scan   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (uop)
                UOP_ADD: begin
                    r_et <= r_et + CNT_W'(1);
                    r_gt <= r_gt + CNT_W'(1);
                end
                UOP_CLEAR: begin
                    r_et <= '0;
                    r_gt <= '0;
                end
                UOP_SG_NEW: begin
                    r_gt <= r_gt + CNT_W'(1);
                end
                UOP_RM_WR: begin
                    r_et <= r_et - CNT_W'(1);
                end
                UOP_DROP_MOVE: begin
                    r_gt   <= r_gt - CNT_W'(1);
                    r_scan <= '0;
                    r_pend <= 1'b0;
                end
                UOP_FIND_INIT: begin
                    r_scan <= '0;
                    r_pend <= 1'b0;
                end
                UOP_FIND, UOP_RENUM: begin
                    r_pend <= scan_more;
                    if (scan_more) begin
                        r_scan <= r_scan + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
            if (uop == UOP_PUBLISH) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // item, work and result payload
    always_ff @(posedge i_clk) begin
        case (uop)
            UOP_ACCEPT: begin
                r_func   <= i_func;
                r_key    <= KS'(i_tile_key);
                r_idx    <= i_entry_index;
                r_tgt    <= i_target_group;
                r_found  <= 1'b0;
                r_rindex <= '0;
                r_status <= ST_OK;
            end
            UOP_RES_FULL: begin
                r_status <= ST_FULL;
            end
            UOP_RES_RANGE: begin
                r_status <= ST_RANGE;
            end
            UOP_ADD: begin
                r_found  <= 1'b1;
                r_rindex <= 6'(r_et);
            end
            UOP_FIND_HIT: begin
                r_found  <= 1'b1;
                r_rindex <= 6'(r_pidx);
            end
            UOP_SG_OLD, UOP_RM_MOVE: begin
                r_old <= goe_rdata;
            end
            UOP_FIND, UOP_RENUM: begin
                r_pidx <= IDX_W'(r_scan);
            end
            UOP_PUBLISH: begin
                r_o_found  <= r_found;
                r_o_rindex <= r_rindex;
                r_o_status <= r_status;
                r_o_et     <= 7'(r_et);
                r_o_gt     <= 7'(r_gt);
            end
            default: begin
            end
        endcase
    end

    // status toward the sequencer
    always_comb begin
        o_stat.func       = r_func;
        o_stat.full       = (r_et >= CNT_W'(MAX_ENTRIES)) || (r_gt >= CNT_W'(MAX_ENTRIES));
        o_stat.sg_bad     = (CMP_W'(r_idx) >= CMP_W'(r_et)) || (CMP_W'(r_tgt) > CMP_W'(r_gt));
        o_stat.rm_bad     = (CMP_W'(r_idx) >= CMP_W'(r_et));
        o_stat.tgt_eq_old = (CMP_W'(r_tgt) == CMP_W'(r_old));
        o_stat.tgt_eq_gt  = (CMP_W'(r_tgt) == CMP_W'(r_gt));
        o_stat.gt_full    = (r_gt >= CNT_W'(MAX_ENTRIES));
        o_stat.cnt_le1    = (gmc_rdata <= CNT_W'(1));
        o_stat.hit        = r_pend && (key_rdata == r_key);
        o_stat.scan_end   = !r_pend && !scan_more;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid      = r_ovalid;
    assign o_found          = r_o_found;
    assign o_result_index   = r_o_rindex;
    assign o_status         = r_o_status;
    assign o_entries_in_use = r_o_et;
    assign o_groups_in_use  = r_o_gt;

`ifndef SYNTHESIS
    // every group has at least one member once an item has settled
    a_groups_le_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop == UOP_PUBLISH) |-> (r_gt <= r_et))
        else $error("group count exceeds entry count");

    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_et <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // a result never overwrites one still waiting
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop == UOP_PUBLISH) |-> out_free)
        else $error("result published over a stalled result");

    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop == UOP_PUBLISH) |=> r_ovalid)
        else $error("published result not presented");

    // renumbering only rewrites entries inside the table
    a_renum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop == UOP_RENUM && goe_we) |-> (CNT_W'(r_pidx) < r_et))
        else $error("renumber write outside the table");
`endif

endmodule

// ===== hdl/group_membership_table_core.sv =====
`timescale 1ns / 1ps
// Sequence: add, clear and rejected items pass from accept through dispatch to publish.
// Find scans the entries in use; set group and remove take longest when a group
// empties and its members are renumbered.
// Throughput: one item at a time; the entry scans over the single read port of
// the key and group memories, one entry a cycle, set the worst case.
// Reset: synchronous active low; entry and group counts go to zero, no memory sweep.
// ----------------------------------------------------------------------------
// group_membership_table_core
// Packed table of keyed entries, each in one group with per-group member
// counts: add, find, set group, remove and clear.
// ----------------------------------------------------------------------------
module group_membership_table_core #(
    parameter int MAX_ENTRIES = gmt_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = gmt_pkg::DEF_KEY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_tile_key,
    input  logic [5:0]  i_entry_index,
    input  logic [6:0]  i_target_group,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [5:0]  o_result_index,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entries_in_use,
    output logic [6:0]  o_groups_in_use
);
    import gmt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    gmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // memories and registers
    gmt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (i_func),
        .i_tile_key       (i_tile_key),
        .i_entry_index    (i_entry_index),
        .i_target_group   (i_target_group),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_found          (o_found),
        .o_result_index   (o_result_index),
        .o_status         (o_status),
        .o_entries_in_use (o_entries_in_use),
        .o_groups_in_use  (o_groups_in_use)
    );

endmodule

// ===== test/tb_group_membership_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_membership_table_core
// Self-checking bench for the group membership table. A small directed run
// covers the corner cases. Random phases then fill, churn and shrink the table
// while sender bursts and receiver stalls vary. A local shadow of the table
// predicts each result, and the monitor compares the results in order.
// ----------------------------------------------------------------------------
module tb_group_membership_table_core;
    import gmt_pkg::*;

    localparam int TABLE_DEPTH  = DEF_MAX_ENTRIES;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 2000;

    // func codes the block does not implement
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] tile_key;
        logic [5:0]  entry_index;
        logic [6:0]  target_group;
    } table_op_t;

    typedef struct packed {
        logic       found;
        logic [5:0] result_index;
        logic [1:0] status;
        logic [6:0] entries_in_use;
        logic [6:0] groups_in_use;
    } table_resp_t;

    typedef enum logic [1:0] {MIX_FILL, MIX_GROW, MIX_CHURN, MIX_SHRINK} op_mix_t;

    logic        i_clk           = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [2:0]  in_func         = FUNC_FIND;
    logic [31:0] in_tile_key     = '0;
    logic [5:0]  in_entry_index  = '0;
    logic [6:0]  in_target_group = '0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic        out_found;
    logic [5:0]  out_result_index;
    logic [1:0]  out_status;
    logic [6:0]  out_entries_in_use;
    logic [6:0]  out_groups_in_use;

    // shadow table
    logic [31:0] slot_key   [TABLE_DEPTH];
    logic [6:0]  slot_group [TABLE_DEPTH];
    logic [6:0]  group_size [TABLE_DEPTH];
    logic [6:0]  n_entries = '0;
    logic [6:0]  n_groups  = '0;

    table_op_t   queued_ops[$];
    table_resp_t due_results[$];
    logic [31:0] key_pool[$];

    int burst_left   = 0;
    int gap_left     = 0;
    int idle_cycles  = 0;
    int mismatches   = 0;
    int n_checked    = 0;
    int full_seen    = 0;
    int range_seen   = 0;
    int find_hits    = 0;
    int peak_entries = 0;
    int func_seen[8] = '{default: 0};

    logic [31:0] rx_pattern = 32'hFFFF_FFFF;
    int          rx_hold    = 0;

    group_membership_table_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_func           (in_func),
        .i_tile_key       (in_tile_key),
        .i_entry_index    (in_entry_index),
        .i_target_group   (in_target_group),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_found          (out_found),
        .o_result_index   (out_result_index),
        .o_status         (out_status),
        .o_entries_in_use (out_entries_in_use),
        .o_groups_in_use  (out_groups_in_use)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one member leaves group g; an emptied group takes the last group's place
    task automatic drop_group_member(input logic [6:0] g);
        int n;
        if (g >= n_groups) return;
        if (group_size[g] != 0) group_size[g]--;
        if (group_size[g] != 0) return;
        group_size[g] = group_size[n_groups - 1];
        n_groups--;
        for (n = 0; n < n_entries; n++)
            if (slot_group[n] == n_groups) slot_group[n] = g;
    endtask

    // apply one item to the shadow table and return the result it must give
    task automatic table_apply(input table_op_t op, output table_resp_t r);
        int         n;
        logic [6:0] old_g;
        r = '0;
        case (op.func)
            FUNC_ADD: begin
                if (n_entries >= TABLE_DEPTH || n_groups >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_key[n_entries]   = op.tile_key;
                    slot_group[n_entries] = n_groups;
                    group_size[n_groups]  = 7'd1;
                    r.found        = 1'b1;
                    r.result_index = n_entries[5:0];
                    n_entries++;
                    n_groups++;
                end
            end
            FUNC_FIND: begin
                for (n = 0; n < n_entries; n++) begin
                    if (!r.found && slot_key[n] == op.tile_key) begin
                        r.found        = 1'b1;
                        r.result_index = n[5:0];
                    end
                end
            end
            FUNC_SET: begin
                if (op.entry_index >= n_entries || op.target_group > n_groups) begin
                    r.status = ST_RANGE;
                end else begin
                    old_g = slot_group[op.entry_index];
                    // same group, or a new group for a lone member or with none free: no change
                    if (op.target_group != old_g &&
                        !(op.target_group == n_groups &&
                          (n_groups >= TABLE_DEPTH || group_size[old_g] <= 1))) begin
                        if (op.target_group == n_groups) begin
                            group_size[n_groups] = '0;
                            n_groups++;
                        end
                        slot_group[op.entry_index] = op.target_group;
                        group_size[op.target_group]++;
                        drop_group_member(old_g);
                    end
                end
            end
            FUNC_REM: begin
                if (op.entry_index >= n_entries) begin
                    r.status = ST_RANGE;
                end else begin
                    old_g = slot_group[op.entry_index];
                    slot_key[op.entry_index]   = slot_key[n_entries - 1];
                    slot_group[op.entry_index] = slot_group[n_entries - 1];
                    n_entries--;
                    drop_group_member(old_g);
                end
            end
            FUNC_CLEAR: begin
                n_entries = '0;
                n_groups  = '0;
            end
            default: r.status = ST_RANGE;
        endcase
        r.entries_in_use = n_entries;
        r.groups_in_use  = n_groups;
    endtask

    function automatic table_op_t mk_op(logic [2:0] f, logic [31:0] k, logic [5:0] idx,
                                        logic [6:0] tgt);
        table_op_t op;
        op = {f, k, idx, tgt};
        return op;
    endfunction

    // append one item to the driver's pending list
    task automatic queue_op(input table_op_t op);
        queued_ops.insert(queued_ops.size(), op);
    endtask

    // random item shaped by the current table fill and the phase mix
    function automatic table_op_t make_random_op(op_mix_t mix);
        table_op_t op;
        int        pick;
        int        add_cut, find_cut, set_cut, rem_cut;
        op.func         = FUNC_FIND;
        op.tile_key     = $urandom();
        op.entry_index  = 6'($urandom_range(0, 63));
        op.target_group = 7'($urandom_range(0, 127));
        case (mix)
            MIX_FILL:  begin add_cut = 88; find_cut = 96; set_cut = 99; rem_cut = 100; end
            MIX_GROW:  begin add_cut = 40; find_cut = 58; set_cut = 82; rem_cut = 94;  end
            MIX_CHURN: begin add_cut = 25; find_cut = 45; set_cut = 70; rem_cut = 92;  end
            default:   begin add_cut = 10; find_cut = 28; set_cut = 48; rem_cut = 93;  end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < add_cut) begin
            op.func = FUNC_ADD;
            // extreme keys now and then, and duplicates of earlier keys
            case ($urandom_range(0, 19))
                0:          op.tile_key = '0;
                1:          op.tile_key = '1;
                2, 3, 4, 5: if (key_pool.size() != 0)
                                op.tile_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                default:    ;
            endcase
            key_pool.insert(key_pool.size(), op.tile_key);
            if (key_pool.size() > 32) void'(key_pool.pop_front());
        end else if (pick < find_cut) begin
            op.func = FUNC_FIND;
            pick = $urandom_range(0, 9);
            if (pick < 4 && n_entries != 0)
                op.tile_key = slot_key[$urandom_range(0, n_entries - 1)];
            else if (pick < 7 && key_pool.size() != 0)
                op.tile_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (pick < set_cut) begin
            op.func = FUNC_SET;
            if (n_entries != 0) begin
                op.entry_index = 6'($urandom_range(0, n_entries - 1));
                pick = $urandom_range(0, 19);
                if (pick < 9 && n_groups != 0)
                    op.target_group = 7'($urandom_range(0, n_groups - 1));
                else if (pick < 15)
                    op.target_group = n_groups;
                else if (pick < 18)
                    op.target_group = slot_group[op.entry_index];
                else
                    op.target_group = 7'($urandom_range(0, n_groups));
            end
        end else if (pick < rem_cut) begin
            op.func = FUNC_REM;
            if (n_entries != 0) op.entry_index = 6'($urandom_range(0, n_entries - 1));
        end else begin
            // rejected items and the occasional clear
            case ($urandom_range(0, 5))
                0, 4: op.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
                1: begin
                    op.func = FUNC_SET;
                    if (n_entries < TABLE_DEPTH)
                        op.entry_index = 6'($urandom_range(n_entries, TABLE_DEPTH - 1));
                end
                2: begin
                    op.func         = FUNC_SET;
                    op.target_group = 7'($urandom_range(n_groups + 1, 127));
                    if (n_entries != 0) op.entry_index = 6'($urandom_range(0, n_entries - 1));
                end
                3: begin
                    op.func = FUNC_REM;
                    if (n_entries < TABLE_DEPTH)
                        op.entry_index = 6'($urandom_range(n_entries, TABLE_DEPTH - 1));
                end
                default: op.func = FUNC_CLEAR;
            endcase
        end
        return op;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // driver: predicts each accepted item, then loads the next in bursts
    always @(posedge i_clk) begin : driver
        table_op_t   cur;
        table_resp_t want;
        logic        valid_nxt;
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_valid && in_ready) begin
                cur = {in_func, in_tile_key, in_entry_index, in_target_group};
                table_apply(cur, want);
                due_results.insert(due_results.size(), want);
                func_seen[cur.func]++;
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_RANGE) range_seen++;
                if (cur.func == FUNC_FIND && want.found) find_hits++;
                if (int'(n_entries) > peak_entries) peak_entries = int'(n_entries);
            end
            if (!in_valid || in_ready) begin
                valid_nxt = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_ops.size() != 0) begin
                    cur = queued_ops.pop_front();
                    in_func         <= cur.func;
                    in_tile_key     <= cur.tile_key;
                    in_entry_index  <= cur.entry_index;
                    in_target_group <= cur.target_group;
                    valid_nxt = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            9:       gap_left = $urandom_range(10, 24);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 8);
                    end
                end
                in_valid <= valid_nxt;
            end
        end
    end

    // receiver: ready follows a rotating pattern that changes now and then
    always @(posedge i_clk) begin : receiver
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (rx_hold == 0) begin
                case ($urandom_range(0, 4))
                    0:       rx_pattern = 32'hFFFF_FFFF;
                    1:       rx_pattern = $urandom() | 32'h1;
                    2:       rx_pattern = ($urandom() & $urandom()) | 32'h1;
                    3:       rx_pattern = 32'h1;
                    default: rx_pattern = 32'hAAAA_AAAA;
                endcase
                rx_hold = $urandom_range(50, 300);
            end else begin
                rx_hold--;
            end
            rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
            out_ready <= rx_pattern[0];
        end
    end

    // monitor: each result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        table_resp_t want;
        if (rst_n && out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                $error("result with no item outstanding: status %0d entries %0d",
                       out_status, out_entries_in_use);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("found", want.found, out_found);
                check_field("result_index", want.result_index, out_result_index);
                check_field("status", want.status, out_status);
                check_field("entries_in_use", want.entries_in_use, out_entries_in_use);
                check_field("groups_in_use", want.groups_in_use, out_groups_in_use);
                n_checked++;
            end
        end
    end

    // watchdog: ends a run in which nothing moves
    always @(posedge i_clk) begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no item moved for %0d cycles", IDLE_LIMIT);
            $display("group_membership_table_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        op_mix_t mix;
        int      phase_len;
        int      n_made;

        // directed corner cases
        queue_op(mk_op(FUNC_FIND, 32'h1234_5678, 6'd0, 7'd0));  // empty table
        queue_op(mk_op(FUNC_REM, 32'h0, 6'd0, 7'd0));           // index out of range
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd0, 7'd0));           // index out of range
        queue_op(mk_op(FUNC_UNUSED_LO, 32'hFFFF_FFFF, 6'd63, 7'd127));
        queue_op(mk_op(FUNC_UNUSED_LO + 3'd1, 32'h0, 6'd0, 7'd64));
        queue_op(mk_op(FUNC_UNUSED_HI, 32'hA5A5_5A5A, 6'd21, 7'd42));
        queue_op(mk_op(FUNC_ADD, 32'h0, 6'd0, 7'd0));
        queue_op(mk_op(FUNC_ADD, 32'hFFFF_FFFF, 6'd63, 7'd127));
        queue_op(mk_op(FUNC_ADD, 32'h0, 6'd0, 7'd0));           // duplicate key
        queue_op(mk_op(FUNC_FIND, 32'h0, 6'd0, 7'd0));          // lowest match
        queue_op(mk_op(FUNC_FIND, 32'hFFFF_FFFF, 6'd0, 7'd0));
        queue_op(mk_op(FUNC_FIND, 32'h5A5A_0001, 6'd0, 7'd0));  // miss
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd0, 7'd0));           // own group
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd0, 7'd3));           // lone to new group
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd2, 7'd0));           // last group empties
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd0, 7'd2));           // opens a new group
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd1, 7'd0));           // empties, renumbers
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd1, 7'd127));         // target out of range
        queue_op(mk_op(FUNC_SET, 32'h0, 6'd63, 7'd0));          // index out of range
        queue_op(mk_op(FUNC_REM, 32'h0, 6'd0, 7'd0));           // last moves in
        queue_op(mk_op(FUNC_REM, 32'h0, 6'd63, 7'd0));          // index out of range
        queue_op(mk_op(FUNC_CLEAR, 32'h0, 6'd0, 7'd0));
        queue_op(mk_op(FUNC_FIND, 32'h0, 6'd0, 7'd0));          // miss after clear

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // random phases; the first fills the table up to full
        mix       = MIX_FILL;
        phase_len = 90;
        n_made    = 0;
        while (n_made < RANDOM_ITEMS) begin
            @(negedge i_clk);
            if (queued_ops.size() == 0) begin
                queue_op(make_random_op(mix));
                n_made++;
                phase_len--;
                if (phase_len == 0) begin
                    mix       = op_mix_t'($urandom_range(0, 3));
                    phase_len = $urandom_range(40, 100);
                end
            end
        end

        while (queued_ops.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d results checked: %0d add, %0d find, %0d set group, %0d remove, %0d clear",
                 n_checked, func_seen[FUNC_ADD], func_seen[FUNC_FIND], func_seen[FUNC_SET],
                 func_seen[FUNC_REM], func_seen[FUNC_CLEAR]);
        $display("%0d table full, %0d out of range, %0d find hits, peak fill %0d entries",
                 full_seen, range_seen, find_hits, peak_entries);
        if (mismatches == 0) begin
            $display("group_membership_table_core: match");
        end else begin
            $display("group_membership_table_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gmt_pkg.sv
hdl/gmt_ram.sv
hdl/gmt_ctrl.sv
hdl/gmt_datapath.sv
hdl/group_membership_table_core.sv
test/tb_group_membership_table_core.sv
